/* rtl/rhcc_pkg.sv */
// ---------------------------------------------------------------------------
// rhcc_pkg
// Shared constants, register codes and bundle types of the RGB to HSV
// color classifier.
// ---------------------------------------------------------------------------
package rhcc_pkg;

    // Channel and field widths
    localparam int SAMPLE_BITS = 10;
    localparam int GAIN_W      = 12;
    localparam int FRAC_W      = 8;
    localparam int HUE_W       = 9;
    localparam int SAT_W       = 8;
    localparam int SAT_AVG_W   = 8;
    localparam int VAL_AVG_W   = 10;
    localparam int SAT_THR_W   = SAT_AVG_W + GAIN_W;
    localparam int VAL_THR_W   = VAL_AVG_W + GAIN_W;

    // Divider sizing: both quotients fit in eight bits, two bits per cycle
    localparam int QUOT_W      = 8;
    localparam int DIV_STEPS   = QUOT_W / 2;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int HUE_NUM_W   = SAMPLE_BITS + 6;
    localparam int SAT_NUM_W   = SAMPLE_BITS + 8;
    localparam int DIV_W       = SAMPLE_BITS + QUOT_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_RED,
        REG_GAIN_GREEN,
        REG_GAIN_BLUE,
        REG_SAT_AVG,
        REG_VAL_AVG,
        REG_MARKER_SAT_FACTOR,
        REG_BRIGHT_FACTOR,
        REG_DARK_FACTOR
    } cfg_reg_t;

    // Register reset values
    localparam logic [GAIN_W-1:0]    GAIN_RESET        = GAIN_W'(256);
    localparam logic [SAT_AVG_W-1:0] SAT_AVG_RESET     = '0;
    localparam logic [VAL_AVG_W-1:0] VAL_AVG_RESET     = '0;
    localparam logic [GAIN_W-1:0]    MARKER_SAT_RESET  = GAIN_W'(256);
    localparam logic [GAIN_W-1:0]    BRIGHT_RESET      = GAIN_W'(256);
    localparam logic [GAIN_W-1:0]    DARK_RESET        = GAIN_W'(128);

    // Hue and saturation scaling
    localparam logic [HUE_NUM_W-1:0] HUE_SCALE      = HUE_NUM_W'(60);
    localparam logic [SAT_NUM_W-1:0] SAT_SCALE      = SAT_NUM_W'(255);
    localparam logic [HUE_W-1:0]     HUE_BASE_RED   = HUE_W'(0);
    localparam logic [HUE_W-1:0]     HUE_BASE_GREEN = HUE_W'(120);
    localparam logic [HUE_W-1:0]     HUE_BASE_BLUE  = HUE_W'(240);
    localparam logic [HUE_W:0]       HUE_WRAP       = (HUE_W + 1)'(360);

    // Live configuration, with the flag thresholds already multiplied out
    typedef struct packed {
        logic [GAIN_W-1:0]    gain_red;
        logic [GAIN_W-1:0]    gain_green;
        logic [GAIN_W-1:0]    gain_blue;
        logic [SAT_THR_W-1:0] sat_thr;
        logic [VAL_THR_W-1:0] bright_thr;
        logic [VAL_THR_W-1:0] dark_thr;
    } cfg_t;

    // One classified sample waiting for its divisions
    typedef struct packed {
        logic [HUE_NUM_W-1:0]   hue_num;
        logic [SAMPLE_BITS-1:0] hue_den;
        logic                   hue_neg;
        logic [HUE_W-1:0]       hue_base;
        logic [SAT_NUM_W-1:0]   sat_num;
        logic [SAMPLE_BITS-1:0] sat_den;
        logic [SAMPLE_BITS-1:0] value;
        logic                   bright;
        logic                   dark_ok;
    } work_t;

endpackage

/* rtl/rhcc_if.sv */
// ---------------------------------------------------------------------------
// rhcc_if
// Valid/ready channel interfaces of the color classifier: sample input,
// result output and configuration write.
// ---------------------------------------------------------------------------
interface rhcc_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [rhcc_pkg::SAMPLE_BITS-1:0]     raw_red;
    logic [rhcc_pkg::SAMPLE_BITS-1:0]     raw_green;
    logic [rhcc_pkg::SAMPLE_BITS-1:0]     raw_blue;

    modport source (output valid, output raw_red, output raw_green, output raw_blue,
                    input ready);
    modport sink   (input valid, input raw_red, input raw_green, input raw_blue,
                    output ready);
endinterface

interface rhcc_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [rhcc_pkg::HUE_W-1:0]           hue;
    logic [rhcc_pkg::SAT_W-1:0]           saturation;
    logic [rhcc_pkg::SAMPLE_BITS-1:0]     brightness;
    logic                                 marker_seen;
    logic                                 brighter;

    modport source (output valid, output hue, output saturation, output brightness,
                    output marker_seen, output brighter, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input marker_seen, input brighter, output ready);
endinterface

interface rhcc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rhcc_pkg::CFG_IDX_W-1:0]       index;
    logic [rhcc_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/rhcc_front.sv */
// ---------------------------------------------------------------------------
// rhcc_front
// Takes a raw sample, applies the channel gains, then finds max and min and
// prepares the hue and saturation divisions and the brightness flags.
// ---------------------------------------------------------------------------
module rhcc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  rhcc_pkg::cfg_t      cfg,
    rhcc_sample_if.sink         sample,
    output logic                push_valid,
    input  logic                push_ready,
    output rhcc_pkg::work_t     push_data
);

    localparam int SB = rhcc_pkg::SAMPLE_BITS;

    // Multiply by a 4.8 gain, drop the fraction and clamp to the channel range
    function automatic logic [SB-1:0] scale_chan(input logic [SB-1:0] raw,
                                                 input logic [rhcc_pkg::GAIN_W-1:0] gain);
        logic [SB+rhcc_pkg::GAIN_W-1:0] prod;
        prod = {{rhcc_pkg::GAIN_W{1'b0}}, raw} * {{SB{1'b0}}, gain};
        if (|prod[SB+rhcc_pkg::GAIN_W-1:SB+rhcc_pkg::FRAC_W])
            return '1;
        else
            return prod[SB+rhcc_pkg::FRAC_W-1:rhcc_pkg::FRAC_W];
    endfunction

    logic          valid_reg, valid_next;
    logic [SB-1:0] red_reg, green_reg, blue_reg;
    logic [SB-1:0] red_next, green_next, blue_next;

    logic [SB-1:0] mx, mn, dlt, mag, diff_a, diff_b;
    logic signed [SB:0] diff;
    logic          blue_max, green_max, grey;
    logic [rhcc_pkg::HUE_W-1:0] base;
    logic [rhcc_pkg::VAL_THR_W-1:0] val_sh;

    // Hold the scaled sample until the queue takes it
    assign sample.ready = !valid_reg || push_ready;
    assign push_valid   = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (sample.ready)
            valid_next = sample.valid;
        if (sample.valid && sample.ready)
        begin
            red_next   = scale_chan(sample.raw_red,   cfg.gain_red);
            green_next = scale_chan(sample.raw_green, cfg.gain_green);
            blue_next  = scale_chan(sample.raw_blue,  cfg.gain_blue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    // Find max and min; blue wins ties over green, green over red
    always_comb
    begin
        mx = red_reg;
        if (green_reg > mx) mx = green_reg;
        if (blue_reg > mx)  mx = blue_reg;
        mn = red_reg;
        if (green_reg < mn) mn = green_reg;
        if (blue_reg < mn)  mn = blue_reg;
        dlt       = mx - mn;
        grey      = (dlt == '0);
        blue_max  = (blue_reg == mx);
        green_max = !blue_max && (green_reg == mx);
    end

    // Pick the hue sector and its signed channel difference
    always_comb
    begin
        if (blue_max)
        begin
            diff_a = red_reg;
            diff_b = green_reg;
            base   = rhcc_pkg::HUE_BASE_BLUE;
        end
        else if (green_max)
        begin
            diff_a = blue_reg;
            diff_b = red_reg;
            base   = rhcc_pkg::HUE_BASE_GREEN;
        end
        else
        begin
            diff_a = green_reg;
            diff_b = blue_reg;
            base   = rhcc_pkg::HUE_BASE_RED;
        end
        diff = $signed({1'b0, diff_a}) - $signed({1'b0, diff_b});
        mag  = diff[SB] ? SB'(-diff) : diff[SB-1:0];
    end

    // Build the division operands; grey and black force a zero quotient
    always_comb
    begin
        val_sh = rhcc_pkg::VAL_THR_W'({mx, {rhcc_pkg::FRAC_W{1'b0}}});

        push_data.hue_num  = grey ? '0 : rhcc_pkg::HUE_NUM_W'(mag) * rhcc_pkg::HUE_SCALE;
        push_data.hue_den  = grey ? SB'(1) : dlt;
        push_data.hue_neg  = diff[SB];
        push_data.hue_base = grey ? rhcc_pkg::HUE_BASE_RED : base;
        push_data.sat_num  = rhcc_pkg::SAT_NUM_W'(dlt) * rhcc_pkg::SAT_SCALE;
        push_data.sat_den  = (mx == '0) ? SB'(1) : mx;
        push_data.value    = mx;
        push_data.bright   = val_sh > cfg.bright_thr;
        push_data.dark_ok  = val_sh > cfg.dark_thr;
    end

endmodule

/* rtl/rhcc_queue.sv */
// ---------------------------------------------------------------------------
// rhcc_queue
// Small FIFO between the classifying front and the dividing back, so that
// each side stalls on its own.
// ---------------------------------------------------------------------------
module rhcc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  rhcc_pkg::work_t     push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output rhcc_pkg::work_t     pop_data
);

    localparam int PW = rhcc_pkg::QPTR_W;

    rhcc_pkg::work_t entry_reg [rhcc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            push, pop;

    assign push_ready = (count_reg != (PW + 1)'(rhcc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(rhcc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(rhcc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry on push
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/rhcc_back.sv */
// ---------------------------------------------------------------------------
// rhcc_back
// Runs the hue and saturation divisions side by side, two quotient bits per
// cycle, then forms the final hue, the marker flag and the result register.
// ---------------------------------------------------------------------------
module rhcc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rhcc_pkg::cfg_t      cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  rhcc_pkg::work_t     pop_data,
    rhcc_result_if.source       result
);

    localparam int SB = rhcc_pkg::SAMPLE_BITS;
    localparam int DW = rhcc_pkg::DIV_W;
    localparam int QW = rhcc_pkg::QUOT_W;
    localparam int HW = rhcc_pkg::HUE_W;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] dsh;
        logic [QW-1:0] q;
    } div_state_t;

    // One restoring step: subtract the shifted divisor when it fits
    function automatic div_state_t div_step(input div_state_t s);
        div_state_t n;
        n = s;
        if (s.rem >= s.dsh)
        begin
            n.rem = s.rem - s.dsh;
            n.q   = {s.q[QW-2:0], 1'b1};
        end
        else
            n.q   = {s.q[QW-2:0], 1'b0};
        n.dsh = s.dsh >> 1;
        return n;
    endfunction

    logic                       busy_reg, busy_next;
    logic [rhcc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    div_state_t                 hue_div_reg, hue_div_next, hue_two;
    div_state_t                 sat_div_reg, sat_div_next, sat_two;
    logic                       hue_neg_reg, hue_neg_next;
    logic [HW-1:0]              hue_base_reg, hue_base_next;
    logic [SB-1:0]              value_reg, value_next;
    logic                       bright_reg, bright_next;
    logic                       dark_ok_reg, dark_ok_next;

    logic                       out_valid_reg, out_valid_next;
    logic [HW-1:0]              out_hue_reg, out_hue_next;
    logic [rhcc_pkg::SAT_W-1:0] out_sat_reg, out_sat_next;
    logic [SB-1:0]              out_value_reg, out_value_next;
    logic                       out_marker_reg, out_marker_next;
    logic                       out_bright_reg, out_bright_next;

    logic                       last, out_free, finish, load;
    logic [HW:0]                hue_wide;
    logic                       marker;

    assign hue_two   = div_step(div_step(hue_div_reg));
    assign sat_two   = div_step(div_step(sat_div_reg));
    assign last      = busy_reg && (cnt_reg == rhcc_pkg::CNT_W'(rhcc_pkg::DIV_STEPS - 1));
    assign out_free  = !out_valid_reg || result.ready;
    assign finish    = last && out_free;
    assign pop_ready = !busy_reg || finish;
    assign load      = pop_valid && pop_ready;

    // Apply the sign and sector base, wrap a negative hue, check saturation
    always_comb
    begin
        if (hue_neg_reg)
            hue_wide = {1'b0, hue_base_reg} - (HW + 1)'(hue_two.q);
        else
            hue_wide = {1'b0, hue_base_reg} + (HW + 1)'(hue_two.q);
        if (hue_wide[HW])
            hue_wide = hue_wide + rhcc_pkg::HUE_WRAP;
        marker = dark_ok_reg &&
                 (rhcc_pkg::SAT_THR_W'({sat_two.q, {rhcc_pkg::FRAC_W{1'b0}}}) > cfg.sat_thr);
    end

    // Advance the divisions, retire into the result register, load the next item
    always_comb
    begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        hue_div_next  = hue_div_reg;
        sat_div_next  = sat_div_reg;
        hue_neg_next  = hue_neg_reg;
        hue_base_next = hue_base_reg;
        value_next    = value_reg;
        bright_next   = bright_reg;
        dark_ok_next  = dark_ok_reg;

        if (busy_reg && !last)
        begin
            hue_div_next = hue_two;
            sat_div_next = sat_two;
            cnt_next     = cnt_reg + 1'b1;
        end
        if (finish)
            busy_next = 1'b0;
        if (load)
        begin
            busy_next        = 1'b1;
            cnt_next         = '0;
            hue_div_next.rem = DW'(pop_data.hue_num);
            hue_div_next.dsh = DW'(pop_data.hue_den) << (QW - 1);
            hue_div_next.q   = '0;
            sat_div_next.rem = DW'(pop_data.sat_num);
            sat_div_next.dsh = DW'(pop_data.sat_den) << (QW - 1);
            sat_div_next.q   = '0;
            hue_neg_next     = pop_data.hue_neg;
            hue_base_next    = pop_data.hue_base;
            value_next       = pop_data.value;
            bright_next      = pop_data.bright;
            dark_ok_next     = pop_data.dark_ok;
        end
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_hue_next    = out_hue_reg;
        out_sat_next    = out_sat_reg;
        out_value_next  = out_value_reg;
        out_marker_next = out_marker_reg;
        out_bright_next = out_bright_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (finish)
        begin
            out_valid_next  = 1'b1;
            out_hue_next    = hue_wide[HW-1:0];
            out_sat_next    = sat_two.q;
            out_value_next  = value_reg;
            out_marker_next = marker;
            out_bright_next = bright_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_div_reg    <= hue_div_next;
        sat_div_reg    <= sat_div_next;
        hue_neg_reg    <= hue_neg_next;
        hue_base_reg   <= hue_base_next;
        value_reg      <= value_next;
        bright_reg     <= bright_next;
        dark_ok_reg    <= dark_ok_next;
        out_hue_reg    <= out_hue_next;
        out_sat_reg    <= out_sat_next;
        out_value_reg  <= out_value_next;
        out_marker_reg <= out_marker_next;
        out_bright_reg <= out_bright_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.hue         = out_hue_reg;
    assign result.saturation  = out_sat_reg;
    assign result.brightness  = out_value_reg;
    assign result.marker_seen = out_marker_reg;
    assign result.brighter    = out_bright_reg;

endmodule

/* rtl/rgb_to_hsv_color_classifier_unit.sv */
// ---------------------------------------------------------------------------
// rgb_to_hsv_color_classifier_unit
// Gain-corrects RGB sensor samples and converts them to hue, saturation
// and value, with a marker flag and a brighter-than-average flag.
// ---------------------------------------------------------------------------
// Usage:
//   sample : valid/ready input, one raw RGB reading per transfer.
//   result : valid/ready output, one hue/saturation/brightness result and
//            two flags per sample, in input order.
//   cfg    : valid/ready register write port, always ready; index selects
//            gain_red, gain_green, gain_blue, saturation_average,
//            value_average, marker_sat_factor, bright_factor, dark_factor.
//            Write only while no sample is in flight.
// Divider: the single divider pair in the back end retires two quotient
//   bits per cycle for 8-bit quotients, the last two once the result
//   register is free; a new sample loads only as the last one retires.
//   The front end and a 2-entry queue absorb short bursts.
// Reset: registers return to unity gains, zero averages, marker and bright
//   factors of 1.0, dark factor of 0.5; the pipeline empties.
// Stall: a stalled receiver holds the result register; the back end waits,
//   the queue fills and sample.ready falls once front and queue are full.
// ---------------------------------------------------------------------------
module rgb_to_hsv_color_classifier_unit (
    input  logic           clk,
    input  logic           rst_n,
    rhcc_sample_if.sink    sample,
    rhcc_result_if.source  result,
    rhcc_cfg_if.sink       cfg
);

    logic [rhcc_pkg::GAIN_W-1:0]    gain_red_reg, gain_green_reg, gain_blue_reg;
    logic [rhcc_pkg::SAT_AVG_W-1:0] sat_avg_reg;
    logic [rhcc_pkg::VAL_AVG_W-1:0] val_avg_reg;
    logic [rhcc_pkg::GAIN_W-1:0]    marker_sat_reg, bright_reg, dark_reg;
    logic [rhcc_pkg::SAT_THR_W-1:0] sat_thr_reg;
    logic [rhcc_pkg::VAL_THR_W-1:0] bright_thr_reg, dark_thr_reg;

    rhcc_pkg::cfg_t  cfg_bus;
    logic            push_valid, push_ready, pop_valid, pop_ready;
    rhcc_pkg::work_t push_data, pop_data;

    assign cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_red_reg   <= rhcc_pkg::GAIN_RESET;
            gain_green_reg <= rhcc_pkg::GAIN_RESET;
            gain_blue_reg  <= rhcc_pkg::GAIN_RESET;
            sat_avg_reg    <= rhcc_pkg::SAT_AVG_RESET;
            val_avg_reg    <= rhcc_pkg::VAL_AVG_RESET;
            marker_sat_reg <= rhcc_pkg::MARKER_SAT_RESET;
            bright_reg     <= rhcc_pkg::BRIGHT_RESET;
            dark_reg       <= rhcc_pkg::DARK_RESET;
        end
        else if (cfg.valid)
        begin
            case (rhcc_pkg::cfg_reg_t'(cfg.index))
                rhcc_pkg::REG_GAIN_RED:          gain_red_reg   <= cfg.data;
                rhcc_pkg::REG_GAIN_GREEN:        gain_green_reg <= cfg.data;
                rhcc_pkg::REG_GAIN_BLUE:         gain_blue_reg  <= cfg.data;
                rhcc_pkg::REG_SAT_AVG:
                    sat_avg_reg <= cfg.data[rhcc_pkg::SAT_AVG_W-1:0];
                rhcc_pkg::REG_VAL_AVG:
                    val_avg_reg <= cfg.data[rhcc_pkg::VAL_AVG_W-1:0];
                rhcc_pkg::REG_MARKER_SAT_FACTOR: marker_sat_reg <= cfg.data;
                rhcc_pkg::REG_BRIGHT_FACTOR:     bright_reg     <= cfg.data;
                rhcc_pkg::REG_DARK_FACTOR:       dark_reg       <= cfg.data;
                default:                         ;
            endcase
        end
    end

    // Precompute the flag thresholds; averages reset to zero, so do these
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_thr_reg    <= '0;
            bright_thr_reg <= '0;
            dark_thr_reg   <= '0;
        end
        else
        begin
            sat_thr_reg    <= {{rhcc_pkg::GAIN_W{1'b0}}, sat_avg_reg} *
                              {{rhcc_pkg::SAT_AVG_W{1'b0}}, marker_sat_reg};
            bright_thr_reg <= {{rhcc_pkg::GAIN_W{1'b0}}, val_avg_reg} *
                              {{rhcc_pkg::VAL_AVG_W{1'b0}}, bright_reg};
            dark_thr_reg   <= {{rhcc_pkg::GAIN_W{1'b0}}, val_avg_reg} *
                              {{rhcc_pkg::VAL_AVG_W{1'b0}}, dark_reg};
        end
    end

    always_comb
    begin
        cfg_bus.gain_red   = gain_red_reg;
        cfg_bus.gain_green = gain_green_reg;
        cfg_bus.gain_blue  = gain_blue_reg;
        cfg_bus.sat_thr    = sat_thr_reg;
        cfg_bus.bright_thr = bright_thr_reg;
        cfg_bus.dark_thr   = dark_thr_reg;
    end

    rhcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rhcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rhcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .result     (result)
    );

endmodule
